@@ src/det_pkg.sv @@
// Shared types and constants for the delayed event slot table.
package det_pkg;

    localparam int SLOTS_DEF    = 32;
    localparam int SLOT_FIELD_W = 5;
    localparam int TIME_W       = 32;
    localparam int TAG_W        = 16;
    localparam int S_DATA_W     = 88;
    localparam int M_DATA_W     = 64;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_INACTIVE = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_FREE_RANK,
        ST_SWEEP,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Control from the sequencer to the due-slot compare unit
    typedef struct packed {
        logic clear;
        logic hit_en;
    } scan_ctl_t;

endpackage

@@ src/det_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module det_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/det_scan.sv @@
// Due-slot compare unit: one slot per cycle, keeps the newest due slot seen.
module det_scan #(
    parameter int SLOTS = det_pkg::SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  det_pkg::scan_ctl_t            ctl,
    input  logic [$clog2(SLOTS)-1:0]      slot_idx,
    input  logic [$clog2(SLOTS)-1:0]      slot_rank,
    input  logic [det_pkg::TIME_W-1:0]    slot_trig,
    input  logic [det_pkg::TAG_W-1:0]     slot_tag,
    input  logic [det_pkg::TIME_W-1:0]    elapsed,
    output logic                          due_found,
    output logic [$clog2(SLOTS)-1:0]      due_idx,
    output logic [det_pkg::TAG_W-1:0]     due_tag,
    output logic [det_pkg::TIME_W-1:0]    due_trig
);

    import det_pkg::*;

    localparam int SW = $clog2(SLOTS);

    logic              found_reg, found_next;
    logic [SW-1:0]     idx_reg, idx_next;
    logic [SW-1:0]     rank_reg, rank_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [TIME_W-1:0] trig_reg, trig_next;
    logic              is_due;
    logic              is_newer;

    assign is_due   = ctl.hit_en && (slot_trig < elapsed);
    assign is_newer = !found_reg || (slot_rank > rank_reg);

    always_comb begin
        found_next = found_reg;
        idx_next   = idx_reg;
        rank_next  = rank_reg;
        tag_next   = tag_reg;
        trig_next  = trig_reg;
        if (ctl.clear) begin
            found_next = 1'b0;
            idx_next   = '0;
            rank_next  = '0;
            tag_next   = '0;
            trig_next  = '0;
        end else if (is_due && is_newer) begin
            found_next = 1'b1;
            idx_next   = slot_idx;
            rank_next  = slot_rank;
            tag_next   = slot_tag;
            trig_next  = slot_trig;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        idx_reg  <= idx_next;
        rank_reg <= rank_next;
        tag_reg  <= tag_next;
        trig_reg <= trig_next;
    end

    assign due_found = found_reg;
    assign due_idx   = idx_reg;
    assign due_tag   = tag_reg;
    assign due_trig  = trig_reg;

endmodule

@@ src/delayed_event_slot_table.sv @@
// Delayed event slot table: sequencer, slot stores, free stack and time base.
// A create that succeeds pops a slot; a free that succeeds reads the
//   victim's rank and runs the rank update pass; each request then scans the
//   slots through the compare unit, one slot per cycle, and posts its result.
// Throughput: one request at a time; s_tready is high only while idle.
// Reset: synchronous active-low aresetn clears time, active bits and the free
//   stack (pool full of free slots 0..SLOTS-1); slot stores are not cleared.
module delayed_event_slot_table #(
    parameter int SLOTS = det_pkg::SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // delta[31:0], trigger_at[63:32], event_tag[79:64], free_slot[84:80], zero pad
    input  logic [det_pkg::S_DATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // new_slot[4:0], due_valid[5], due_slot[10:6], due_tag[26:11],
    // due_trigger[58:27], zero pad
    output logic [det_pkg::M_DATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [1:0]                      m_tuser
);

    import det_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [TIME_W-1:0]       delta_reg, delta_next;
    logic [TIME_W-1:0]       trig_in_reg, trig_in_next;
    logic [TAG_W-1:0]        tag_in_reg, tag_in_next;
    logic [SLOT_FIELD_W-1:0] victim_reg, victim_next;
    logic [TIME_W-1:0]       elapsed_reg, elapsed_next;
    logic [SLOTS-1:0]        active_reg, active_next;
    logic [CW-1:0]           free_count_reg, free_count_next;
    logic [CW-1:0]           hi_mark_reg, hi_mark_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    pv_reg, pv_next;
    logic [SW-1:0]           pidx_reg, pidx_next;
    logic [SW-1:0]           victim_rank_reg, victim_rank_next;
    stat_t                   status_reg, status_next;
    logic [SW-1:0]           new_slot_reg, new_slot_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]     m_data_reg, m_data_next;
    stat_t                   m_status_reg, m_status_next;

    logic [CW-1:0]           top;
    logic [CW-1:0]           top_inc;
    logic [CW-1:0]           top_dec;
    logic [SW-1:0]           top_idx;
    logic [SW-1:0]           cnt_idx;
    logic [SW-1:0]           victim_idx;
    logic                    victim_in_range;
    logic [SW-1:0]           pop_slot;
    logic                    pass_done;
    logic                    dec_hit;
    logic                    push_en;

    logic [SW-1:0]           stack_rd;
    logic [SW-1:0]           rank_rd;
    logic [TIME_W-1:0]       trig_rd;
    logic [TAG_W-1:0]        tag_rd;
    logic                    rank_we;
    logic [SW-1:0]           rank_waddr;
    logic [SW-1:0]           rank_wdata;
    logic [SW-1:0]           rank_raddr;

    scan_ctl_t               scan_ctl;
    logic                    due_found;
    logic [SW-1:0]           due_idx;
    logic [TAG_W-1:0]        due_tag;
    logic [TIME_W-1:0]       due_trig;

    // Stack top sits at SLOTS - free_count; entries at or above hi_mark were
    // never written, so a pop from there takes the top index itself as the slot.
    assign top             = CW'(SLOTS) - free_count_reg;
    assign top_inc         = top + 1'b1;
    assign top_dec         = top - 1'b1;
    assign top_idx         = top[SW-1:0];
    assign cnt_idx         = cnt_reg[SW-1:0];
    assign victim_idx      = SW'(victim_reg);
    assign victim_in_range = 32'(victim_reg) < 32'(SLOTS);
    assign pop_slot        = (top >= hi_mark_reg) ? top_idx : stack_rd;
    assign pass_done       = (cnt_reg == CW'(SLOTS)) && !pv_reg;
    assign dec_hit         = (state_reg == ST_SWEEP) && pv_reg && active_reg[pidx_reg]
                             && (rank_rd > victim_rank_reg);
    assign push_en         = (state_reg == ST_SWEEP) && pass_done
                             && (free_count_reg < CW'(SLOTS));

    assign rank_we    = (state_reg == ST_POP) || dec_hit;
    assign rank_waddr = (state_reg == ST_POP) ? pop_slot : pidx_reg;
    assign rank_wdata = (state_reg == ST_POP) ? top_idx : (rank_rd - 1'b1);
    assign rank_raddr = (state_reg == ST_EXEC) ? victim_idx : cnt_idx;

    det_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (push_en),
        .wr_addr (top_dec[SW-1:0]),
        .wr_data (victim_idx),
        .rd_addr (top_idx),
        .rd_data (stack_rd)
    );

    det_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (rank_waddr),
        .wr_data (rank_wdata),
        .rd_addr (rank_raddr),
        .rd_data (rank_rd)
    );

    det_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_trig_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_POP),
        .wr_addr (pop_slot),
        .wr_data (trig_in_reg),
        .rd_addr (cnt_idx),
        .rd_data (trig_rd)
    );

    det_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_POP),
        .wr_addr (pop_slot),
        .wr_data (tag_in_reg),
        .rd_addr (cnt_idx),
        .rd_data (tag_rd)
    );

    det_scan #(.SLOTS(SLOTS)) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .slot_idx  (pidx_reg),
        .slot_rank (rank_rd),
        .slot_trig (trig_rd),
        .slot_tag  (tag_rd),
        .elapsed   (elapsed_reg),
        .due_found (due_found),
        .due_idx   (due_idx),
        .due_tag   (due_tag),
        .due_trig  (due_trig)
    );

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        delta_next       = delta_reg;
        trig_in_next     = trig_in_reg;
        tag_in_next      = tag_in_reg;
        victim_next      = victim_reg;
        elapsed_next     = elapsed_reg;
        active_next      = active_reg;
        free_count_next  = free_count_reg;
        hi_mark_next     = hi_mark_reg;
        cnt_next         = cnt_reg;
        pv_next          = pv_reg;
        pidx_next        = pidx_reg;
        victim_rank_next = victim_rank_reg;
        status_next      = status_reg;
        new_slot_next    = new_slot_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_status_next    = m_status_reg;
        scan_ctl.clear   = 1'b0;
        scan_ctl.hit_en  = (state_reg == ST_SCAN) && pv_reg && active_reg[pidx_reg];

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = cmd_t'(s_tuser);
                    delta_next   = s_tdata[31:0];
                    trig_in_next = s_tdata[63:32];
                    tag_in_next  = s_tdata[79:64];
                    victim_next  = s_tdata[84:80];
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                status_next   = STAT_OK;
                new_slot_next = '0;
                cnt_next      = '0;
                pv_next       = 1'b0;
                case (cmd_reg)
                    CMD_TICK: begin
                        elapsed_next   = elapsed_reg + delta_reg;
                        scan_ctl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    CMD_CREATE: begin
                        if (free_count_reg == '0) begin
                            status_next    = STAT_FULL;
                            scan_ctl.clear = 1'b1;
                            state_next     = ST_SCAN;
                        end else begin
                            state_next = ST_POP;
                        end
                    end
                    CMD_FREE: begin
                        if (!victim_in_range || !active_reg[victim_idx]) begin
                            status_next    = STAT_INACTIVE;
                            scan_ctl.clear = 1'b1;
                            state_next     = ST_SCAN;
                        end else begin
                            active_next[victim_idx] = 1'b0;
                            state_next              = ST_FREE_RANK;
                        end
                    end
                    default: begin
                        scan_ctl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                endcase
            end
            ST_POP: begin
                active_next[pop_slot] = 1'b1;
                free_count_next       = free_count_reg - 1'b1;
                hi_mark_next          = (top_inc > hi_mark_reg) ? top_inc : hi_mark_reg;
                new_slot_next         = pop_slot;
                scan_ctl.clear        = 1'b1;
                state_next            = ST_SCAN;
            end
            ST_FREE_RANK: begin
                victim_rank_next = rank_rd;
                state_next       = ST_SWEEP;
            end
            ST_SWEEP, ST_SCAN: begin
                // Issue one slot read per cycle; data comes back in the next cycle
                if (cnt_reg != CW'(SLOTS)) begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_idx;
                    cnt_next  = cnt_reg + 1'b1;
                end else begin
                    pv_next = 1'b0;
                end
                if (pass_done) begin
                    cnt_next = '0;
                    pv_next  = 1'b0;
                    if (state_reg == ST_SWEEP) begin
                        if (push_en) begin
                            free_count_next = free_count_reg + 1'b1;
                        end
                        scan_ctl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_data_next   = {5'b0,
                                     due_found ? due_trig : {TIME_W{1'b0}},
                                     due_found ? due_tag : {TAG_W{1'b0}},
                                     due_found ? SLOT_FIELD_W'(due_idx)
                                               : {SLOT_FIELD_W{1'b0}},
                                     due_found,
                                     SLOT_FIELD_W'(new_slot_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            elapsed_reg    <= '0;
            active_reg     <= '0;
            free_count_reg <= CW'(SLOTS);
            hi_mark_reg    <= '0;
            cnt_reg        <= '0;
            pv_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            elapsed_reg    <= elapsed_next;
            active_reg     <= active_next;
            free_count_reg <= free_count_next;
            hi_mark_reg    <= hi_mark_next;
            cnt_reg        <= cnt_next;
            pv_reg         <= pv_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg         <= cmd_next;
        delta_reg       <= delta_next;
        trig_in_reg     <= trig_in_next;
        tag_in_reg      <= tag_in_next;
        victim_reg      <= victim_next;
        pidx_reg        <= pidx_next;
        victim_rank_reg <= victim_rank_next;
        status_reg      <= status_next;
        new_slot_reg    <= new_slot_next;
        m_data_reg      <= m_data_next;
        m_status_reg    <= m_status_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // Every slot is either active or on the free stack between requests
    a_slot_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (($countones(active_reg) + 32'(free_count_reg))
                                    == 32'(SLOTS)))
        else $error("active and free slot counts do not add up");

    // Stack top never passes the written mark
    a_top_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (top <= hi_mark_reg) && (hi_mark_reg <= CW'(SLOTS)))
        else $error("free stack top beyond written mark");

    // A result is raised only from the finish step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish step");

    // A create that pops always leaves the taken slot active
    a_pop_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |=> active_reg[$past(pop_slot)])
        else $error("popped slot not marked active");

endmodule

@@ sim/delayed_event_slot_table_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the delayed event slot table stream interface.
module delayed_event_slot_table_test;
    import det_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 2 * SLOTS + 20;

    typedef struct packed {
        stat_t       status;
        logic [4:0]  new_slot;
        logic        due_valid;
        logic [4:0]  due_slot;
        logic [15:0] due_tag;
        logic [31:0] due_trigger;
    } slot_result_t;

    typedef struct packed {
        cmd_t         cmd;
        logic [31:0]  delta;
        logic [31:0]  trig;
        logic [15:0]  tag;
        logic [4:0]   slot;
        logic         typed;
        slot_result_t res;
    } plan_row_t;

    typedef enum int {EP_FILL, EP_DRAIN, EP_TIMING, EP_NOISE} episode_t;

    localparam int PLAN_ROWS = 21;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{CMD_TICK,   32'h0,         32'h0,         16'h0,    5'd0,  1'b1,
          '{STAT_OK,       5'd0, 1'b0, 5'd0, 16'h0,    32'h0}},
        '{CMD_FREE,   32'h0,         32'h0,         16'h0,    5'd0,  1'b1,
          '{STAT_INACTIVE, 5'd0, 1'b0, 5'd0, 16'h0,    32'h0}},
        '{CMD_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 1'b1,
          '{STAT_OK,       5'd0, 1'b0, 5'd0, 16'h0,    32'h0}},
        '{CMD_CREATE, 32'h0,         32'h0,         16'hFFFF, 5'd0,  1'b1,
          '{STAT_OK,       5'd0, 1'b0, 5'd0, 16'h0,    32'h0}},
        '{CMD_CREATE, 32'h0,         32'hFFFF_FFFF, 16'h0,    5'd0,  1'b1,
          '{STAT_OK,       5'd1, 1'b0, 5'd0, 16'h0,    32'h0}},
        '{CMD_TICK,   32'h1,         32'h0,         16'h0,    5'd0,  1'b1,
          '{STAT_OK,       5'd0, 1'b1, 5'd0, 16'hFFFF, 32'h0}},
        // wrap back to zero: nothing is due
        '{CMD_TICK,   32'hFFFF_FFFF, 32'h0,         16'h0,    5'd0,  1'b1,
          '{STAT_OK,       5'd0, 1'b0, 5'd0, 16'h0,    32'h0}},
        '{CMD_TICK,   32'hFFFF_FFFF, 32'h0,         16'h0,    5'd0,  1'b1,
          '{STAT_OK,       5'd0, 1'b1, 5'd0, 16'hFFFF, 32'h0}},
        '{CMD_CREATE, 32'h0,         32'h7FFF_FFFF, 16'h00A5, 5'd0,  1'b1,
          '{STAT_OK,       5'd2, 1'b1, 5'd2, 16'h00A5, 32'h7FFF_FFFF}},
        '{CMD_FREE,   32'h0,         32'h0,         16'h0,    5'd1,  1'b0, '0},
        '{CMD_FREE,   32'h0,         32'h0,         16'h0,    5'd1,  1'b1,
          '{STAT_INACTIVE, 5'd0, 1'b1, 5'd2, 16'h00A5, 32'h7FFF_FFFF}},
        '{CMD_CREATE, 32'h0,         32'h5,         16'h1234, 5'd0,  1'b0, '0},
        '{CMD_FREE,   32'h0,         32'h0,         16'h0,    5'd2,  1'b0, '0},
        '{CMD_FREE,   32'h0,         32'h0,         16'h0,    5'd0,  1'b0, '0},
        '{CMD_CREATE, 32'h0,         32'hFFFF_FFFE, 16'h5A5A, 5'd0,  1'b0, '0},
        '{CMD_FREE,   32'h0,         32'h0,         16'h0,    5'd31, 1'b0, '0},
        '{CMD_NOP,    32'h0,         32'h0,         16'h0,    5'd0,  1'b0, '0},
        '{CMD_TICK,   32'h8000_0000, 32'h0,         16'h0,    5'd0,  1'b0, '0},
        '{CMD_FREE,   32'h0,         32'h0,         16'h0,    5'd1,  1'b0, '0},
        '{CMD_FREE,   32'h0,         32'h0,         16'h0,    5'd0,  1'b0, '0},
        '{CMD_TICK,   32'h0000_0100, 32'h0,         16'h0,    5'd0,  1'b0, '0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;

    // predicted table contents
    logic [31:0] now_time;
    logic [31:0] slot_trig   [SLOTS];
    logic [15:0] slot_tagv   [SLOTS];
    logic        slot_live   [SLOTS];
    int          slot_order  [SLOTS];
    logic [4:0]  spare_stack [SLOTS];
    int          spare_count;

    slot_result_t pending_results [$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  sent         = 0;
    int  full_hits    = 0;
    int  stale_frees  = 0;
    int  due_reports  = 0;
    int  cycles       = 0;
    bit  sender_steady = 1'b0;

    delayed_event_slot_table #(.SLOTS(SLOTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic slot_result_t apply_request(input cmd_t cmd, input logic [31:0] delta,
                                                   input logic [31:0] trig,
                                                   input logic [15:0] tag,
                                                   input logic [4:0] slot);
        slot_result_t r;
        logic [4:0]   s;
        int           pos;
        int           best;
        bit           hit;
        r = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_TICK: now_time = now_time + delta;
            CMD_CREATE: begin
                if (spare_count == 0) begin
                    r.status = STAT_FULL;
                end else begin
                    s = spare_stack[SLOTS - spare_count];
                    spare_count--;
                    slot_live[s]  = 1'b1;
                    slot_trig[s]  = trig;
                    slot_tagv[s]  = tag;
                    slot_order[s] = SLOTS - 1 - spare_count;
                    r.new_slot    = s;
                end
            end
            CMD_FREE: begin
                if (!slot_live[slot]) begin
                    r.status = STAT_INACTIVE;
                end else begin
                    pos = slot_order[slot];
                    slot_live[slot] = 1'b0;
                    // close the gap in creation order
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i] && slot_order[i] > pos)
                            slot_order[i]--;
                    spare_count++;
                    spare_stack[SLOTS - spare_count] = slot;
                end
            end
            default: ;
        endcase
        hit  = 1'b0;
        best = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && slot_trig[i] < now_time &&
                (!hit || slot_order[i] > slot_order[best])) begin
                best = i;
                hit  = 1'b1;
            end
        end
        if (hit) begin
            r.due_valid   = 1'b1;
            r.due_slot    = best[4:0];
            r.due_tag     = slot_tagv[best];
            r.due_trigger = slot_trig[best];
        end
        return r;
    endfunction

    // Half the time near the current time, so the due test flips often
    function automatic logic [31:0] pick_trigger();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return now_time - $urandom_range(0, 8);
            2: return now_time + $urandom_range(0, 8);
            default: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [4:0] pick_victim();
        int base;
        base = $urandom_range(0, SLOTS - 1);
        if ($urandom_range(0, 3) != 0)
            for (int k = 0; k < SLOTS; k++)
                if (slot_live[(base + k) % SLOTS])
                    return 5'((base + k) % SLOTS);
        return 5'(base);
    endfunction

    task automatic offer_request(input cmd_t cmd, input logic [31:0] delta,
                                 input logic [31:0] trig, input logic [15:0] tag,
                                 input logic [4:0] slot, input logic typed,
                                 input slot_result_t typed_res);
        int           gap;
        slot_result_t predicted;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            // sometimes start the gap only once the table is idle
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge aclk); while (s_tready !== 1'b1);
            end
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, slot, tag, trig, delta};
        do @(posedge aclk); while (!(s_tvalid === 1'b1 && s_tready === 1'b1));
        predicted = apply_request(cmd, delta, trig, tag, slot);
        if (predicted.status == STAT_FULL)     full_hits++;
        if (predicted.status == STAT_INACTIVE) stale_frees++;
        if (predicted.due_valid)               due_reports++;
        pending_results.push_back(typed ? typed_res : predicted);
        sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic field_check(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, seen);
            mismatches++;
        end
    endtask

    // Result side: random stalls, one long hold-off, and a stretch without stalls
    initial begin
        int           stall;
        bit           held;
        slot_result_t want;
        held     = 1'b0;
        m_tready = 1'b1;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(negedge aclk);
            stall = (results_seen >= 250 && results_seen < 320) ? 0 : $urandom_range(0, 9);
            if (!held && results_seen == HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (stall != 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (m_tvalid !== 1'b1);
                repeat (stall) @(negedge aclk);
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no request pending, expected none, got 0x%0h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                field_check("status",      want.status,      m_tuser);
                field_check("new_slot",    want.new_slot,    m_tdata[4:0]);
                field_check("due_valid",   want.due_valid,   m_tdata[5]);
                field_check("due_slot",    want.due_slot,    m_tdata[10:6]);
                field_check("due_tag",     want.due_tag,     m_tdata[26:11]);
                field_check("due_trigger", want.due_trigger, m_tdata[58:27]);
            end
            results_seen++;
        end
    end

    initial begin
        cmd_t        cmd;
        logic [31:0] delta;
        logic [31:0] trig;
        logic [15:0] tag;
        logic [4:0]  slot;
        episode_t    kind;
        int          roll;
        int          len;
        int          made;
        bit          paused;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_NOP;
        now_time    = '0;
        spare_count = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            slot_trig[i]   = '0;
            slot_tagv[i]   = '0;
            slot_live[i]   = 1'b0;
            slot_order[i]  = 0;
            spare_stack[i] = 5'(i);
        end
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
            offer_request(PLAN[i].cmd, PLAN[i].delta, PLAN[i].trig, PLAN[i].tag,
                          PLAN[i].slot, PLAN[i].typed, PLAN[i].res);
        drain_results();

        made   = 0;
        paused = 1'b0;
        while (made < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            kind = roll < 3 ? EP_FILL : roll < 5 ? EP_DRAIN : roll < 9 ? EP_TIMING : EP_NOISE;
            if (made == 0) kind = EP_FILL;
            sender_steady = ($urandom_range(0, 4) == 0);
            len = (kind == EP_FILL) ? $urandom_range(8, 40) : $urandom_range(1, 12);
            repeat (len) begin
                // unused fields carry random bits too
                delta = $urandom;
                trig  = $urandom;
                tag   = 16'($urandom);
                slot  = 5'($urandom);
                case (kind)
                    EP_FILL: begin
                        cmd  = CMD_CREATE;
                        trig = pick_trigger();
                    end
                    EP_DRAIN: begin
                        cmd  = CMD_FREE;
                        slot = pick_victim();
                    end
                    EP_TIMING: begin
                        case ($urandom_range(0, 2))
                            0: begin
                                cmd = CMD_TICK;
                                if ($urandom_range(0, 7) != 0) delta = $urandom_range(0, 40);
                            end
                            1: begin
                                cmd  = CMD_CREATE;
                                trig = pick_trigger();
                            end
                            default: begin
                                cmd  = CMD_FREE;
                                slot = pick_victim();
                            end
                        endcase
                    end
                    default: cmd = cmd_t'(2'($urandom_range(0, 3)));
                endcase
                offer_request(cmd, delta, trig, tag, slot, 1'b0, '0);
                if (cmd != CMD_NOP) made++;
                if (!paused && made >= RANDOM_ITEMS * 3 / 5) begin
                    paused = 1'b1;
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        $display("Sent %0d requests (%0d from the directed table), checked %0d results.",
                 sent, PLAN_ROWS, results_seen);
        $display("Seen %0d pool-full replies, %0d frees of idle slots, %0d due reports.",
                 full_hits, stale_frees, due_reports);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
